FILE: sv/wcs_pkg.sv
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared widths, constants and types of the wavelet coefficient shrinkage core.
// ----------------------------------------------------------------------------
package wcs_pkg;

    // Fixed point format of the coefficient fields (Q12.12)
    localparam int COEF_W = 24;
    localparam int FRAC_W = 12;
    localparam int VAR_W  = 32;
    localparam int VS_W   = VAR_W + FRAC_W;   // variance aligned to 2F fraction bits
    localparam int SQ_W   = 2 * COEF_W;       // square of a coefficient

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SIGMA     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIVARIATE_NOISE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_SCALE    = 8'd3;

    typedef enum logic [1:0] {
        MODE_WIENER    = 2'd0,
        MODE_LAPLACE   = 2'd1,
        MODE_BIVARIATE = 2'd2,
        MODE_BYPASS    = 2'd3
    } t_mode;

    // Constants in Q1.30
    localparam int K_W = 31;
    localparam logic [K_W-1:0] SQRT2_Q30     = 31'd1518500250;
    localparam logic [K_W-1:0] SQRT3_Q30     = 31'd1859775393;
    localparam logic [K_W-1:0] INV_SQRT2_Q30 = 31'd759250125;
    localparam int K_FRAC = 30;

    // Threshold numerator: floor(x^2 * K / 2^30)
    localparam int THR_W = SQ_W + 1;

    // Integer square root, two root bits per stage, two lanes side by side
    localparam int ROOT_LANES  = 2;
    localparam int RAD_W       = SQ_W;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int ROOT_REM_W  = ROOT_W + 2;
    localparam int ROOT_STEPS  = 2;
    localparam int ROOT_STAGES = ROOT_W / ROOT_STEPS;

    // Restoring divider with a saturating quotient
    localparam int QUOT_W      = COEF_W + 1;
    localparam int DIV_N_W     = 3 * COEF_W;
    localparam int DIV_D_W     = SQ_W + 1;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

    // Register count from the accepting edge to the result register
    localparam int LATENCY = 4 + (ROOT_STAGES + 1) + 3 + 2 * (DIV_STAGES + 1) + 1;

    // Per-item fields that travel alongside the arithmetic
    typedef struct packed {
        logic              neg;
        logic [COEF_W-1:0] w1;
        logic [COEF_W-1:0] s;
        logic [COEF_W-1:0] r;
        logic [QUOT_W-1:0] res;
    } t_side;

    // Configuration and values derived from it
    typedef struct packed {
        t_mode             mode;
        logic              pscale;
        logic [SQ_W-1:0]   n2;
        logic [THR_W-1:0]  thr_n;
        logic [THR_W-1:0]  thr_b;
    } t_cfg;

endpackage

FILE: sv/wavelet_coefficient_shrinkage_core.sv
// ----------------------------------------------------------------------------
// wavelet_coefficient_shrinkage_core
// Bivariate / Wiener / Laplacian wavelet coefficient shrinkage, Q12.12.
// ----------------------------------------------------------------------------
// Throughput: one coefficient per cycle; busy stays low, so start may be held.
// Depth: front end 4, square root 13, glue 3, two dividers 14 each, output 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears all valid bits and the registers
// to their defaults (Wiener, zero noise, parent divided by two).
// ----------------------------------------------------------------------------
module wavelet_coefficient_shrinkage_core import wcs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item channel
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic signed [COEF_W-1:0] i_parent_coefficient,
    input  logic [VAR_W-1:0]         i_local_variance,
    input  logic                     i_window_inside,
    // result channel
    output logic                     o_strobe,
    output logic signed [COEF_W-1:0] o_denoised_coefficient,
    output logic [COEF_W-1:0]        o_signal_sigma,
    // register writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PQ_W = COEF_W + K_FRAC;
    localparam int HALF_W = SQ_W / 2;

    t_cfg w_cfg;

    // Registers are taken at any time; the pipeline never pushes back.
    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    wcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ------------------------------------------------------------------
    // Front end: capture, magnitudes, variance minus noise^2, squares
    // ------------------------------------------------------------------
    logic                r_v0, r_v1, r_v2, r_v3;
    logic [COEF_W-1:0]   r_c0, r_p0;
    logic [VAR_W-1:0]    r_var0;
    logic                r_in0;

    logic                r_neg1, r_neg2, r_neg3;
    logic [COEF_W-1:0]   r_w1_1, r_w1_2, r_w1_3;
    logic [COEF_W-1:0]   r_p1, r_q2;
    logic [VS_W-1:0]     r_d1, r_d2, r_d3;
    logic [SQ_W-1:0]     r_w1sq2, r_w1sq3, r_qsq3;

    logic [COEF_W-1:0]   n_w1, n_p;
    logic [VS_W-1:0]     n_vs, n_d;
    logic [SQ_W-1:0]     n_vs_ext, n_diff;
    logic [PQ_W-1:0]     n_pq;
    logic [COEF_W-1:0]   n_q;

    always_comb begin
        n_w1     = r_c0[COEF_W-1] ? (~r_c0 + 1'b1) : r_c0;
        n_p      = r_p0[COEF_W-1] ? (~r_p0 + 1'b1) : r_p0;
        n_vs     = {r_var0, {FRAC_W{1'b0}}};
        n_vs_ext = {{(SQ_W-VS_W){1'b0}}, n_vs};
        n_diff   = n_vs_ext - w_cfg.n2;
        // sigma is zero at borders and when noise swamps the variance
        n_d      = (r_in0 && (n_vs_ext > w_cfg.n2)) ? n_diff[VS_W-1:0] : '0;
    end

    // parent scaled down by two or by sqrt two
    assign n_pq = r_p1 * INV_SQRT2_Q30[K_FRAC-1:0];
    assign n_q  = w_cfg.pscale ? {1'b0, r_p1[COEF_W-1:1]} : n_pq[PQ_W-1:K_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0    <= i_coefficient;
        r_p0    <= i_parent_coefficient;
        r_var0  <= i_local_variance;
        r_in0   <= i_window_inside;

        r_neg1  <= r_c0[COEF_W-1];
        r_w1_1  <= n_w1;
        r_p1    <= n_p;
        r_d1    <= n_d;

        r_neg2  <= r_neg1;
        r_w1_2  <= r_w1_1;
        r_q2    <= n_q;
        r_w1sq2 <= r_w1_1 * r_w1_1;
        r_d2    <= r_d1;

        r_neg3  <= r_neg2;
        r_w1_3  <= r_w1_2;
        r_w1sq3 <= r_w1sq2;
        r_qsq3  <= r_q2 * r_q2;
        r_d3    <= r_d2;
    end

    // ------------------------------------------------------------------
    // Square roots: lane 0 gives sigma, lane 1 the bivariate radius
    // ------------------------------------------------------------------
    t_side                               w_sq_side_in, w_sq_side;
    logic [ROOT_LANES-1:0][RAD_W-1:0]    w_rad;
    logic [ROOT_LANES-1:0][ROOT_W-1:0]   w_root;
    logic                                w_sq_v;

    always_comb begin
        w_sq_side_in      = '0;
        w_sq_side_in.neg  = r_neg3;
        w_sq_side_in.w1   = r_w1_3;
        w_rad[0]          = {{(RAD_W-VS_W){1'b0}}, r_d3};
        w_rad[1]          = r_w1sq3 + r_qsq3;
    end

    wcs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_side  (w_sq_side_in),
        .i_rad   (w_rad),
        .o_valid (w_sq_v),
        .o_side  (w_sq_side),
        .o_root  (w_root)
    );

    // ------------------------------------------------------------------
    // s^2, then |w1| * s^2 as two half products
    // ------------------------------------------------------------------
    logic              r_vp1, r_vp2;
    t_side             r_sp1, r_sp2;
    logic [SQ_W-1:0]   r_s2p1, r_s2p2;
    logic [SQ_W-1:0]   r_lo, r_hi;
    t_side             n_sp1;

    always_comb begin
        n_sp1   = w_sq_side;
        n_sp1.s = w_root[0][COEF_W-1:0];
        n_sp1.r = w_root[1][COEF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp1 <= 1'b0;
            r_vp2 <= 1'b0;
        end else begin
            r_vp1 <= w_sq_v;
            r_vp2 <= r_vp1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp1  <= n_sp1;
        r_s2p1 <= n_sp1.s * n_sp1.s;
        r_sp2  <= r_sp1;
        r_s2p2 <= r_s2p1;
        r_lo   <= r_sp1.w1 * r_s2p1[HALF_W-1:0];
        r_hi   <= r_sp1.w1 * r_s2p1[SQ_W-1:HALF_W];
    end

    // ------------------------------------------------------------------
    // First divide: Wiener result, or threshold / sigma for the Laplacian and bivariate rules
    // ------------------------------------------------------------------
    logic [DIV_N_W-1:0] n_num1;
    logic [DIV_D_W-1:0] n_den1;
    logic [DIV_N_W-1:0] n_wn;

    assign n_wn = {r_hi, {HALF_W{1'b0}}} + {{(DIV_N_W-SQ_W){1'b0}}, r_lo};

    always_comb begin
        case (w_cfg.mode)
            MODE_WIENER: begin
                n_num1 = n_wn;
                n_den1 = {1'b0, r_s2p2} + {1'b0, w_cfg.n2};
            end
            MODE_LAPLACE: begin
                n_num1 = {{(DIV_N_W-THR_W){1'b0}}, w_cfg.thr_n};
                n_den1 = {{(DIV_D_W-COEF_W){1'b0}}, r_sp2.s};
            end
            MODE_BIVARIATE: begin
                n_num1 = {{(DIV_N_W-THR_W){1'b0}}, w_cfg.thr_b};
                n_den1 = {{(DIV_D_W-COEF_W){1'b0}}, r_sp2.s};
            end
            default: begin
                n_num1 = '0;
                n_den1 = {{(DIV_D_W-1){1'b0}}, 1'b1};
            end
        endcase
    end

    logic              w_d1_v;
    t_side             w_d1_side;
    logic [QUOT_W-1:0] w_q1;

    wcs_div u_div_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vp2),
        .i_side  (r_sp2),
        .i_num   (n_num1),
        .i_den   (n_den1),
        .o_valid (w_d1_v),
        .o_side  (w_d1_side),
        .o_quot  (w_q1)
    );

    // ------------------------------------------------------------------
    // Apply threshold: result for Wiener / Laplacian, r - T for bivariate
    // ------------------------------------------------------------------
    logic              r_vf;
    t_side             r_sf;
    t_side             n_sf;
    logic [QUOT_W-1:0] n_w1x, n_rx;

    always_comb begin
        n_sf  = w_d1_side;
        n_w1x = {1'b0, w_d1_side.w1};
        n_rx  = {1'b0, w_d1_side.r};
        case (w_cfg.mode)
            MODE_WIENER:    n_sf.res = w_q1;
            MODE_LAPLACE:   n_sf.res = (n_w1x > w_q1) ? (n_w1x - w_q1) : '0;
            MODE_BIVARIATE: n_sf.res = (n_rx > w_q1) ? (n_rx - w_q1) : '0;
            default:        n_sf.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else begin
            r_vf <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sf <= n_sf;
    end

    // ------------------------------------------------------------------
    // Second divide: |w1| * (r - T) / r, bivariate only
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]    n_prod;
    logic [DIV_N_W-1:0] n_num2;
    logic [DIV_D_W-1:0] n_den2;
    logic               w_d2_v;
    t_side              w_d2_side;
    logic [QUOT_W-1:0]  w_q2;

    assign n_prod = r_sf.w1 * r_sf.res[COEF_W-1:0];
    assign n_num2 = {{(DIV_N_W-SQ_W){1'b0}}, n_prod};
    assign n_den2 = {{(DIV_D_W-COEF_W){1'b0}}, r_sf.r};

    wcs_div u_div_biv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vf),
        .i_side  (r_sf),
        .i_num   (n_num2),
        .i_den   (n_den2),
        .o_valid (w_d2_v),
        .o_side  (w_d2_side),
        .o_quot  (w_q2)
    );

    // ------------------------------------------------------------------
    // Final pick, clamp to |w1|, sign restore, result register
    // ------------------------------------------------------------------
    logic              r_out_v;
    logic [COEF_W-1:0] r_den;
    logic [COEF_W-1:0] r_sig;
    logic [QUOT_W-1:0] n_res;
    logic [COEF_W-1:0] n_mag;
    logic [COEF_W-1:0] n_den;

    always_comb begin
        n_res = '0;
        case (w_cfg.mode) inside
            MODE_WIENER, MODE_LAPLACE: n_res = w_d2_side.res;
            MODE_BIVARIATE: begin
                // zero radius only when w1 is zero: pass w1 through
                n_res = (w_d2_side.r == '0) ? {1'b0, w_d2_side.w1} : w_q2;
            end
            default: n_res = {1'b0, w_d2_side.w1};
        endcase
        if (w_cfg.mode != MODE_BYPASS && w_d2_side.s == '0) begin
            n_res = '0;
        end
        if (n_res > {1'b0, w_d2_side.w1}) begin
            n_mag = w_d2_side.w1;
        end else begin
            n_mag = n_res[COEF_W-1:0];
        end
        n_den = w_d2_side.neg ? (~n_mag + 1'b1) : n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= n_den;
        r_sig <= w_d2_side.s;
    end

    assign o_strobe               = r_out_v;
    assign o_denoised_coefficient = signed'(r_den);
    assign o_signal_sigma         = r_sig;

endmodule

FILE: sv/wcs_cfg.sv
// ----------------------------------------------------------------------------
// wcs_cfg
// Register file plus a short pipeline deriving noise squares and thresholds.
// ----------------------------------------------------------------------------
module wcs_cfg import wcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    localparam int HALF_W = SQ_W / 2;
    localparam int PP_W   = HALF_W + K_W;
    localparam int SUM_W  = SQ_W + K_W;

    t_mode              r_mode;
    logic               r_pscale;
    logic [COEF_W-1:0]  r_noise;
    logic [COEF_W-1:0]  r_bnoise;
    logic [SQ_W-1:0]    r_n2;
    logic [SQ_W-1:0]    r_b2;
    logic [PP_W-1:0]    r_pn_lo, r_pn_hi, r_pb_lo, r_pb_hi;
    logic [THR_W-1:0]   r_thr_n, r_thr_b;
    logic [SUM_W-1:0]   n_sum_n, n_sum_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_WIENER;
            r_pscale <= 1'b1;
            r_noise  <= '0;
            r_bnoise <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHRINK_MODE:     r_mode   <= t_mode'(i_cfg_data[1:0]);
                REG_NOISE_SIGMA:     r_noise  <= i_cfg_data[COEF_W-1:0];
                REG_BIVARIATE_NOISE: r_bnoise <= i_cfg_data[COEF_W-1:0];
                REG_PARENT_SCALE:    r_pscale <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // x^2 * K split in two halves, then joined and scaled down by 2^30
    assign n_sum_n = {r_pn_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, r_pn_lo};
    assign n_sum_b = {r_pb_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, r_pb_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n2    <= '0;
            r_b2    <= '0;
            r_pn_lo <= '0;
            r_pn_hi <= '0;
            r_pb_lo <= '0;
            r_pb_hi <= '0;
            r_thr_n <= '0;
            r_thr_b <= '0;
        end else begin
            r_n2    <= r_noise * r_noise;
            r_b2    <= r_bnoise * r_bnoise;
            r_pn_lo <= r_n2[HALF_W-1:0] * SQRT2_Q30;
            r_pn_hi <= r_n2[SQ_W-1:HALF_W] * SQRT2_Q30;
            r_pb_lo <= r_b2[HALF_W-1:0] * SQRT3_Q30;
            r_pb_hi <= r_b2[SQ_W-1:HALF_W] * SQRT3_Q30;
            r_thr_n <= n_sum_n[K_FRAC +: THR_W];
            r_thr_b <= n_sum_b[K_FRAC +: THR_W];
        end
    end

    assign o_cfg.mode   = r_mode;
    assign o_cfg.pscale = r_pscale;
    assign o_cfg.n2     = r_n2;
    assign o_cfg.thr_n  = r_thr_n;
    assign o_cfg.thr_b  = r_thr_b;

endmodule

FILE: sv/wcs_isqrt.sv
// ----------------------------------------------------------------------------
// wcs_isqrt
// Pipelined digit-by-digit integer square root, two lanes, two bits a stage.
// ----------------------------------------------------------------------------
module wcs_isqrt import wcs_pkg::*; (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  t_side                               i_side,
    input  logic [ROOT_LANES-1:0][RAD_W-1:0]    i_rad,
    output logic                                o_valid,
    output t_side                               o_side,
    output logic [ROOT_LANES-1:0][ROOT_W-1:0]   o_root
);

    logic                                    r_v    [ROOT_STAGES+1];
    t_side                                   r_sd   [ROOT_STAGES+1];
    logic [ROOT_LANES-1:0][RAD_W-1:0]        r_x    [ROOT_STAGES+1];
    logic [ROOT_LANES-1:0][ROOT_REM_W-1:0]   r_rem  [ROOT_STAGES+1];
    logic [ROOT_LANES-1:0][ROOT_W-1:0]       r_root [ROOT_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0]   <= i_side;
        r_x[0]    <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar j = 1; j <= ROOT_STAGES; j++) begin : g_stage
        logic [ROOT_LANES-1:0][ROOT_REM_W-1:0] n_rem;
        logic [ROOT_LANES-1:0][ROOT_W-1:0]     n_root;

        always_comb begin
            logic [ROOT_REM_W+1:0] rem2;
            logic [ROOT_REM_W+1:0] diff;
            logic [ROOT_REM_W-1:0] rem;
            logic [ROOT_REM_W-1:0] trial;
            logic [ROOT_W-1:0]     root;
            int                    bi;
            n_rem  = '0;
            n_root = '0;
            for (int l = 0; l < ROOT_LANES; l++) begin
                rem  = r_rem[j-1][l];
                root = r_root[j-1][l];
                for (int k = 0; k < ROOT_STEPS; k++) begin
                    bi    = ROOT_W - 1 - ROOT_STEPS * (j - 1) - k;
                    rem2  = {rem, r_x[j-1][l][2*bi+1 -: 2]};
                    trial = {root, 2'b01};
                    diff  = rem2 - {2'b00, trial};
                    if (rem2 >= {2'b00, trial}) begin
                        rem  = diff[ROOT_REM_W-1:0];
                        root = {root[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem  = rem2[ROOT_REM_W-1:0];
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                end
                n_rem[l]  = rem;
                n_root[l] = root;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sd[j]   <= r_sd[j-1];
            r_x[j]    <= r_x[j-1];
            r_rem[j]  <= n_rem;
            r_root[j] <= n_root;
        end
    end

    assign o_valid = r_v[ROOT_STAGES];
    assign o_side  = r_sd[ROOT_STAGES];
    assign o_root  = r_root[ROOT_STAGES];

endmodule

FILE: sv/wcs_div.sv
// ----------------------------------------------------------------------------
// wcs_div
// Pipelined restoring divider, two quotient bits a stage, saturating quotient.
// ----------------------------------------------------------------------------
module wcs_div import wcs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_valid,
    output t_side              o_side,
    output logic [QUOT_W-1:0]  o_quot
);

    localparam int TOP_W = DIV_N_W - QUOT_W;

    logic               r_v    [DIV_STAGES+1];
    t_side              r_sd   [DIV_STAGES+1];
    logic               r_over [DIV_STAGES+1];
    logic [DIV_N_W-1:0] r_num  [DIV_STAGES+1];
    logic [DIV_D_W-1:0] r_den  [DIV_STAGES+1];
    logic [DIV_D_W-1:0] r_rem  [DIV_STAGES+1];
    logic [QUOT_W-1:0]  r_q    [DIV_STAGES+1];

    logic [DIV_D_W-1:0] n_top;

    // quotient wider than QUOT_W bits when the upper dividend reaches the divisor
    assign n_top = {{(DIV_D_W-TOP_W){1'b0}}, i_num[DIV_N_W-1:QUOT_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0]   <= i_side;
        r_over[0] <= (n_top >= i_den);
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_rem[0]  <= n_top;
        r_q[0]    <= '0;
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
        logic [DIV_D_W-1:0] n_rem;
        logic [QUOT_W-1:0]  n_q;

        always_comb begin
            logic [DIV_D_W:0] rem2;
            logic [DIV_D_W:0] diff;
            int               bi;
            n_rem = r_rem[j-1];
            n_q   = r_q[j-1];
            for (int k = 0; k < DIV_STEPS; k++) begin
                bi = QUOT_W - 1 - DIV_STEPS * (j - 1) - k;
                if (bi >= 0) begin
                    rem2 = {n_rem, r_num[j-1][bi]};
                    diff = rem2 - {1'b0, r_den[j-1]};
                    if (rem2 >= {1'b0, r_den[j-1]}) begin
                        n_rem   = diff[DIV_D_W-1:0];
                        n_q[bi] = 1'b1;
                    end else begin
                        n_rem = rem2[DIV_D_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sd[j]   <= r_sd[j-1];
            r_over[j] <= r_over[j-1];
            r_num[j]  <= r_num[j-1];
            r_den[j]  <= r_den[j-1];
            r_rem[j]  <= n_rem;
            r_q[j]    <= n_q;
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_side  = r_sd[DIV_STAGES];
    assign o_quot  = r_over[DIV_STAGES] ? {QUOT_W{1'b1}} : r_q[DIV_STAGES];

endmodule

FILE: sv/wcs_checker.sv
// ----------------------------------------------------------------------------
// wcs_checker
// Port-level checks on the shrinkage core, bound to the top level.
// ----------------------------------------------------------------------------
module wcs_checker import wcs_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic signed [COEF_W-1:0] i_coefficient,
    input logic                     i_window_inside,
    input logic                     o_strobe,
    input logic signed [COEF_W-1:0] o_denoised_coefficient,
    input logic [COEF_W-1:0]        o_signal_sigma
);

    logic              w_acc;
    logic [COEF_W-1:0] w_in_mag;
    logic [COEF_W-1:0] w_out_mag;

    assign w_acc     = start && !busy;
    assign w_in_mag  = i_coefficient[COEF_W-1] ? (~i_coefficient + 1'b1) : i_coefficient;
    assign w_out_mag = o_denoised_coefficient[COEF_W-1]
                     ? (~o_denoised_coefficient + 1'b1) : o_denoised_coefficient;

    // every beat taken produces a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LATENCY o_strobe)
        else $error("accepted beat did not produce a result");

    // no result without a matching beat taken earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, LATENCY))
        else $error("result without an accepted beat");

    // border windows give zero sigma
    a_border_sigma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_window_inside) |-> ##LATENCY (o_signal_sigma == '0))
        else $error("nonzero sigma for a border window");

    // shrinkage never grows a coefficient or flips its sign
    a_shrink_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (w_out_mag <= $past(w_in_mag, LATENCY)))
        else $error("output magnitude above input magnitude");

    a_shrink_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_denoised_coefficient != '0)
            |-> (o_denoised_coefficient[COEF_W-1] == $past(i_coefficient[COEF_W-1], LATENCY)))
        else $error("output sign differs from input sign");

endmodule

bind wavelet_coefficient_shrinkage_core wcs_checker u_wcs_checker (.*);
